// ===== sv/bcdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdt_pkg
// Shared constants for the binary clock with display timeout: field widths,
// beat layout, register indexes and reset values.
// ----------------------------------------------------------------------------
package bcdt_pkg;

   localparam int LEVEL_COUNT = 5;
   localparam int LEVEL_W     = 3;
   localparam int SEC_W       = 6;
   localparam int MIN_W       = 6;
   localparam int HOUR_W      = 5;
   localparam int TMO_W       = 8;
   localparam int DUTY_W      = 8;
   localparam int TABLE_W     = 40;

   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = TABLE_W;

   // request beat: tdata bit positions
   localparam int REQ_WAKE_BIT   = 0;
   localparam int REQ_MINUTE_BIT = 1;
   localparam int REQ_HOUR_BIT   = 2;

   // response beat: field low bits
   localparam int RSP_MIN_LEDS_LO  = 0;
   localparam int RSP_HOUR_LEDS_LO = RSP_MIN_LEDS_LO + MIN_W;
   localparam int RSP_MIN_DUTY_LO  = RSP_HOUR_LEDS_LO + HOUR_W;
   localparam int RSP_HOUR_DUTY_LO = RSP_MIN_DUTY_LO + DUTY_W;
   localparam int RSP_ON_BIT       = RSP_HOUR_DUTY_LO + DUTY_W;
   localparam int RSP_USED_W       = RSP_ON_BIT + 1;

   // opcode in req_tuser
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_PRESS = 1'b1;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT_RELOAD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MINUTE_TABLE   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOUR_TABLE     = 2'd2;

   localparam logic [TMO_W-1:0]   RELOAD_RESET      = 8'd10;
   localparam logic [TABLE_W-1:0] MINUTE_TBL_RESET  = 40'hFF96643200;
   localparam logic [TABLE_W-1:0] HOUR_TBL_RESET    = 40'hFFFAF5F3F0;

   localparam logic [SEC_W-1:0]   SEC_RESET   = 6'd0;
   localparam logic [MIN_W-1:0]   MIN_RESET   = 6'd0;
   localparam logic [HOUR_W-1:0]  HOUR_RESET  = 5'd12;
   localparam logic [TMO_W-1:0]   TMO_RESET   = 8'd10;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'd2;

   localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
   localparam logic [MIN_W-1:0]   MIN_LAST   = 6'd59;
   localparam logic [HOUR_W-1:0]  HOUR_LAST  = 5'd23;
   localparam logic [LEVEL_W-1:0] LEVEL_LAST = LEVEL_W'(LEVEL_COUNT - 1);

   // pick one duty byte of a packed table
   function automatic logic [DUTY_W-1:0] duty_byte(input logic [TABLE_W-1:0] tbl,
                                                   input logic [LEVEL_W-1:0] lvl);
      logic [DUTY_W-1:0] res;
      res = '0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
         if (lvl == LEVEL_W'(i)) begin
            res = tbl[i*DUTY_W +: DUTY_W];
         end
      end
      return res;
   endfunction

endpackage

// ===== sv/binary_clock_with_display_timeout.sv =====
`timescale 1ns / 1ps
// request beat to response beat: input register, then result register
// throughput: one beat per cycle; while a response waits the request side takes
// one more beat into an empty input register, then stalls
// reset (synchronous, active high): time 12:00:00, timeout 10, level 2,
// registers to their defaults, both pipeline stages empty
// ----------------------------------------------------------------------------
// binary_clock_with_display_timeout
// Seconds/minutes/hours counter with button adjust, brightness level and a
// display timeout that blanks the LED outputs.
// ----------------------------------------------------------------------------
module binary_clock_with_display_timeout (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bcdt_pkg::REQ_DATA_W-1:0]    req_tdata,   // wake_pressed, minute_pressed, hour_pressed, zero pad
   input  logic                               req_tuser,   // opcode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bcdt_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // minute_leds, hour_leds, minute_duty, hour_duty, display_on, zero pad
   input  logic                               csr_we,
   input  logic [bcdt_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [bcdt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [bcdt_pkg::TMO_W-1:0]    reload_ff, reload_in;
   logic [bcdt_pkg::TABLE_W-1:0]  min_tbl_ff, min_tbl_in;
   logic [bcdt_pkg::TABLE_W-1:0]  hour_tbl_ff, hour_tbl_in;

   logic [bcdt_pkg::SEC_W-1:0]    sec_ff, sec_in;
   logic [bcdt_pkg::MIN_W-1:0]    min_ff, min_in;
   logic [bcdt_pkg::HOUR_W-1:0]   hour_ff, hour_in;
   logic [bcdt_pkg::TMO_W-1:0]    tmo_ff, tmo_in;
   logic [bcdt_pkg::LEVEL_W-1:0]  level_ff, level_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_op_ff, s1_op_in;
   logic                          s1_wake_ff, s1_wake_in;
   logic                          s1_minute_ff, s1_minute_in;
   logic                          s1_hour_ff, s1_hour_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bcdt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                          out_free;
   logic                          s1_move;
   logic                          req_take;
   logic                          on_now;
   logic                          on_next;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration registers
   always_comb begin
      reload_in   = reload_ff;
      min_tbl_in  = min_tbl_ff;
      hour_tbl_in = hour_tbl_ff;
      if (csr_we) begin
         unique case (csr_addr)
            bcdt_pkg::CSR_TIMEOUT_RELOAD: reload_in = csr_wdata[bcdt_pkg::TMO_W-1:0];
            bcdt_pkg::CSR_MINUTE_TABLE:   min_tbl_in = csr_wdata;
            bcdt_pkg::CSR_HOUR_TABLE:     hour_tbl_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_op_in     = s1_op_ff;
      s1_wake_in   = s1_wake_ff;
      s1_minute_in = s1_minute_ff;
      s1_hour_in   = s1_hour_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      if (req_take) begin
         s1_op_in     = req_tuser;
         s1_wake_in   = req_tdata[bcdt_pkg::REQ_WAKE_BIT];
         s1_minute_in = req_tdata[bcdt_pkg::REQ_MINUTE_BIT];
         s1_hour_in   = req_tdata[bcdt_pkg::REQ_HOUR_BIT];
      end
   end

   // clock state update
   always_comb begin
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      tmo_in   = tmo_ff;
      level_in = level_ff;
      on_now   = (tmo_ff != '0);
      if (s1_move) begin
         if (s1_op_ff == bcdt_pkg::OP_TICK) begin
            if (sec_ff >= bcdt_pkg::SEC_LAST) begin
               sec_in = '0;
               if (min_ff >= bcdt_pkg::MIN_LAST) begin
                  min_in  = '0;
                  hour_in = (hour_ff >= bcdt_pkg::HOUR_LAST) ? '0 : hour_ff + 1'b1;
               end else begin
                  min_in = min_ff + 1'b1;
               end
            end else begin
               sec_in = sec_ff + 1'b1;
            end
            if (on_now) begin
               tmo_in = tmo_ff - 1'b1;
            end
         end else if (on_now) begin
            if (s1_wake_ff && s1_minute_ff) begin
               level_in = (level_ff >= bcdt_pkg::LEVEL_LAST) ? '0 : level_ff + 1'b1;
               tmo_in   = reload_ff;
            end else if (s1_minute_ff) begin
               min_in = (min_ff >= bcdt_pkg::MIN_LAST) ? '0 : min_ff + 1'b1;
               tmo_in = reload_ff;
            end
            if (s1_hour_ff) begin
               hour_in = (hour_ff >= bcdt_pkg::HOUR_LAST) ? '0 : hour_ff + 1'b1;
               tmo_in  = reload_ff;
            end
         end else if (s1_wake_ff || s1_minute_ff || s1_hour_ff) begin
            tmo_in = reload_ff;
         end
      end
   end

   // result register
   always_comb begin
      on_next      = (tmo_in != '0);
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         rsp_data_in = '0;
         rsp_data_in[bcdt_pkg::RSP_MIN_LEDS_LO +: bcdt_pkg::MIN_W] =
            on_next ? min_in : '0;
         rsp_data_in[bcdt_pkg::RSP_HOUR_LEDS_LO +: bcdt_pkg::HOUR_W] =
            on_next ? hour_in : '0;
         rsp_data_in[bcdt_pkg::RSP_MIN_DUTY_LO +: bcdt_pkg::DUTY_W] =
            bcdt_pkg::duty_byte(min_tbl_ff, level_in);
         rsp_data_in[bcdt_pkg::RSP_HOUR_DUTY_LO +: bcdt_pkg::DUTY_W] =
            bcdt_pkg::duty_byte(hour_tbl_ff, level_in);
         rsp_data_in[bcdt_pkg::RSP_ON_BIT] = on_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff    <= bcdt_pkg::RELOAD_RESET;
         min_tbl_ff   <= bcdt_pkg::MINUTE_TBL_RESET;
         hour_tbl_ff  <= bcdt_pkg::HOUR_TBL_RESET;
         sec_ff       <= bcdt_pkg::SEC_RESET;
         min_ff       <= bcdt_pkg::MIN_RESET;
         hour_ff      <= bcdt_pkg::HOUR_RESET;
         tmo_ff       <= bcdt_pkg::TMO_RESET;
         level_ff     <= bcdt_pkg::LEVEL_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         reload_ff    <= reload_in;
         min_tbl_ff   <= min_tbl_in;
         hour_tbl_ff  <= hour_tbl_in;
         sec_ff       <= sec_in;
         min_ff       <= min_in;
         hour_ff      <= hour_in;
         tmo_ff       <= tmo_in;
         level_ff     <= level_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff     <= s1_op_in;
      s1_wake_ff   <= s1_wake_in;
      s1_minute_ff <= s1_minute_in;
      s1_hour_ff   <= s1_hour_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

// ===== sv/bcdt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdt_assertions
// Port-level checks for the binary clock with display timeout.
// ----------------------------------------------------------------------------
module bcdt_assertions (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [bcdt_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic [bcdt_pkg::MIN_W-1:0]  min_leds;
   logic [bcdt_pkg::HOUR_W-1:0] hour_leds;
   logic                        disp_on;

   assign min_leds  = rsp_tdata[bcdt_pkg::RSP_MIN_LEDS_LO +: bcdt_pkg::MIN_W];
   assign hour_leds = rsp_tdata[bcdt_pkg::RSP_HOUR_LEDS_LO +: bcdt_pkg::HOUR_W];
   assign disp_on   = rsp_tdata[bcdt_pkg::RSP_ON_BIT];

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // blanked display shows no LEDs
   a_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !disp_on |-> min_leds == '0 && hour_leds == '0)
      else $error("LEDs lit while display is off");

   // time fields stay in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> min_leds <= bcdt_pkg::MIN_LAST && hour_leds <= bcdt_pkg::HOUR_LAST)
      else $error("time field out of range");

   // a free output side never stalls the request side
   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request stalled with response side ready");

   // no response straight out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind binary_clock_with_display_timeout bcdt_assertions u_bcdt_assertions (.*);

// ===== verif/bcdt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdt_checker
// Watches the request, response and register ports of the binary clock,
// keeps its own copy of the time, timeout, level and registers, works out
// the display beat each request beat should produce and compares every
// response beat field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bcdt_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [bcdt_pkg::REQ_DATA_W-1:0] req_tdata,   // wake_pressed, minute_pressed, hour_pressed, zero pad
   input  logic                            req_tuser,   // opcode
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [bcdt_pkg::RSP_DATA_W-1:0] rsp_tdata,   // minute_leds, hour_leds, minute_duty, hour_duty, display_on, zero pad
   input  logic                            csr_we,
   input  logic [bcdt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [bcdt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatches,
   output int                              pending_beats
);

   typedef struct packed {
      logic [bcdt_pkg::MIN_W-1:0]  min_leds;
      logic [bcdt_pkg::HOUR_W-1:0] hour_leds;
      logic [bcdt_pkg::DUTY_W-1:0] min_duty;
      logic [bcdt_pkg::DUTY_W-1:0] hour_duty;
      logic                        on;
   } display_type;

   display_type display_q[$];
   display_type seen;
   display_type want;

   logic [bcdt_pkg::SEC_W-1:0]   sec_now;
   logic [bcdt_pkg::MIN_W-1:0]   min_now;
   logic [bcdt_pkg::HOUR_W-1:0]  hour_now;
   logic [bcdt_pkg::TMO_W-1:0]   tmo_now;
   logic [bcdt_pkg::LEVEL_W-1:0] lvl_now;
   logic [bcdt_pkg::TMO_W-1:0]   reload_val;
   logic [bcdt_pkg::TABLE_W-1:0] min_tbl;
   logic [bcdt_pkg::TABLE_W-1:0] hour_tbl;

   int mismatch_cnt = 0;
   int pending_cnt  = 0;

   assign mismatches    = mismatch_cnt;
   assign pending_beats = pending_cnt;

   function automatic logic [bcdt_pkg::MIN_W-1:0] next_minute(
      input logic [bcdt_pkg::MIN_W-1:0] m);
      return (m == bcdt_pkg::MIN_LAST) ? '0 : m + 1'b1;
   endfunction

   function automatic logic [bcdt_pkg::HOUR_W-1:0] next_hour(
      input logic [bcdt_pkg::HOUR_W-1:0] h);
      return (h == bcdt_pkg::HOUR_LAST) ? '0 : h + 1'b1;
   endfunction

   // advance the clock state by one event and queue the display it leaves
   task automatic clock_event(input logic op, input logic wake, input logic minute,
                              input logic hour);
      display_type d;
      if (op == bcdt_pkg::OP_TICK) begin
         if (sec_now == bcdt_pkg::SEC_LAST) begin
            sec_now = '0;
            if (min_now == bcdt_pkg::MIN_LAST) begin
               min_now  = '0;
               hour_now = next_hour(hour_now);
            end else begin
               min_now = min_now + 1'b1;
            end
         end else begin
            sec_now = sec_now + 1'b1;
         end
         if (tmo_now != '0) tmo_now = tmo_now - 1'b1;
      end else if (tmo_now != '0) begin
         if (wake && minute) begin
            lvl_now = (lvl_now == bcdt_pkg::LEVEL_LAST) ? '0 : lvl_now + 1'b1;
            tmo_now = reload_val;
         end else if (minute) begin
            min_now = next_minute(min_now);
            tmo_now = reload_val;
         end
         if (hour) begin
            hour_now = next_hour(hour_now);
            tmo_now  = reload_val;
         end
      end else if (wake || minute || hour) begin
         // blanked: a press only wakes the display
         tmo_now = reload_val;
      end
      d.on        = (tmo_now != '0);
      d.min_leds  = d.on ? min_now : '0;
      d.hour_leds = d.on ? hour_now : '0;
      d.min_duty  = min_tbl[lvl_now*bcdt_pkg::DUTY_W +: bcdt_pkg::DUTY_W];
      d.hour_duty = hour_tbl[lvl_now*bcdt_pkg::DUTY_W +: bcdt_pkg::DUTY_W];
      display_q.push_back(d);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sec_now    = bcdt_pkg::SEC_RESET;
         min_now    = bcdt_pkg::MIN_RESET;
         hour_now   = bcdt_pkg::HOUR_RESET;
         tmo_now    = bcdt_pkg::TMO_RESET;
         lvl_now    = bcdt_pkg::LEVEL_RESET;
         reload_val = bcdt_pkg::RELOAD_RESET;
         min_tbl    = bcdt_pkg::MINUTE_TBL_RESET;
         hour_tbl   = bcdt_pkg::HOUR_TBL_RESET;
         display_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               bcdt_pkg::CSR_TIMEOUT_RELOAD: reload_val = csr_wdata[bcdt_pkg::TMO_W-1:0];
               bcdt_pkg::CSR_MINUTE_TABLE:   min_tbl    = csr_wdata[bcdt_pkg::TABLE_W-1:0];
               bcdt_pkg::CSR_HOUR_TABLE:     hour_tbl   = csr_wdata[bcdt_pkg::TABLE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.min_leds  = rsp_tdata[bcdt_pkg::RSP_MIN_LEDS_LO +: bcdt_pkg::MIN_W];
            seen.hour_leds = rsp_tdata[bcdt_pkg::RSP_HOUR_LEDS_LO +: bcdt_pkg::HOUR_W];
            seen.min_duty  = rsp_tdata[bcdt_pkg::RSP_MIN_DUTY_LO +: bcdt_pkg::DUTY_W];
            seen.hour_duty = rsp_tdata[bcdt_pkg::RSP_HOUR_DUTY_LO +: bcdt_pkg::DUTY_W];
            seen.on        = rsp_tdata[bcdt_pkg::RSP_ON_BIT];
            if (display_q.size() == 0) begin
               $error("response beat with no request outstanding: tdata %h", rsp_tdata);
               mismatch_cnt++;
            end else begin
               want = display_q.pop_front();
               if (seen.min_leds != want.min_leds) begin
                  $error("minute_leds: expected %0d, got %0d", want.min_leds, seen.min_leds);
                  mismatch_cnt++;
               end
               if (seen.hour_leds != want.hour_leds) begin
                  $error("hour_leds: expected %0d, got %0d", want.hour_leds, seen.hour_leds);
                  mismatch_cnt++;
               end
               if (seen.min_duty != want.min_duty) begin
                  $error("minute_duty: expected %0d, got %0d", want.min_duty, seen.min_duty);
                  mismatch_cnt++;
               end
               if (seen.hour_duty != want.hour_duty) begin
                  $error("hour_duty: expected %0d, got %0d", want.hour_duty, seen.hour_duty);
                  mismatch_cnt++;
               end
               if (seen.on != want.on) begin
                  $error("display_on: expected %0d, got %0d", want.on, seen.on);
                  mismatch_cnt++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            clock_event(req_tuser, req_tdata[bcdt_pkg::REQ_WAKE_BIT],
                        req_tdata[bcdt_pkg::REQ_MINUTE_BIT],
                        req_tdata[bcdt_pkg::REQ_HOUR_BIT]);
         end
      end
      pending_cnt = display_q.size();
   end

endmodule

// ===== verif/tb_binary_clock_with_display_timeout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_clock_with_display_timeout
// Drives ticks and button events into the binary clock with random gaps and
// response back-pressure, including one long hold-off that fills the block.
// A directed opening covers every button combination but wake with hour, timeout expiry and
// wake from blank; scripted runs push minutes and hours through their
// wraps; random phases follow under several register settings, the
// extremes among them. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb_binary_clock_with_display_timeout;

   localparam logic [bcdt_pkg::CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;
   localparam int HOLD_CYCLES = 200;
   localparam int HOLD_AFTER  = 300;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [bcdt_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            req_tuser  = bcdt_pkg::OP_TICK;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [bcdt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we     = 1'b0;
   logic [bcdt_pkg::CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [bcdt_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   int mismatches;
   int pending_beats;
   int sent_count = 0;
   bit held       = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   binary_clock_with_display_timeout dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   bcdt_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .pending_beats (pending_beats)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_run();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(1, 4);
      if (r < 85) return $urandom_range(5, 20);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [bcdt_pkg::TABLE_W-1:0] rand_table();
      return {8'($urandom), 32'($urandom)};
   endfunction

   task automatic send_beat(input logic op, input logic wake, input logic minute,
                            input logic hour);
      int gap;
      logic [bcdt_pkg::REQ_DATA_W-1:0] beat;
      beat                           = '0;
      beat[bcdt_pkg::REQ_WAKE_BIT]   = wake;
      beat[bcdt_pkg::REQ_MINUTE_BIT] = minute;
      beat[bcdt_pkg::REQ_HOUR_BIT]   = hour;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= beat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_beat(bcdt_pkg::OP_TICK, 1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   task automatic send_presses(input int n, input logic wake, input logic minute,
                               input logic hour);
      repeat (n) send_beat(bcdt_pkg::OP_PRESS, wake, minute, hour);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_regs(input logic [bcdt_pkg::TMO_W-1:0] reload,
                            input logic [bcdt_pkg::TABLE_W-1:0] mtbl,
                            input logic [bcdt_pkg::TABLE_W-1:0] htbl, input bit poke_spare);
      csr_we    <= 1'b1;
      csr_addr  <= bcdt_pkg::CSR_TIMEOUT_RELOAD;
      csr_wdata <= {32'($urandom), reload};
      @(posedge clock);
      csr_addr  <= bcdt_pkg::CSR_MINUTE_TABLE;
      csr_wdata <= mtbl;
      @(posedge clock);
      csr_addr  <= bcdt_pkg::CSR_HOUR_TABLE;
      csr_wdata <= htbl;
      @(posedge clock);
      if (poke_spare) begin
         csr_addr  <= CSR_SPARE;
         csr_wdata <= rand_table();
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random(input int n);
      int done_cnt;
      int len;
      int kind;
      done_cnt = 0;
      while (done_cnt < n) begin
         kind = $urandom_range(0, 99);
         if (kind < 10) begin
            len = $urandom_range(20, 70);
            send_ticks(len);
         end else if (kind < 50) begin
            len = $urandom_range(1, 8);
            send_ticks(len);
         end else begin
            len = $urandom_range(1, 5);
            repeat (len) send_beat(bcdt_pkg::OP_PRESS, 1'($urandom), 1'($urandom),
                                   1'($urandom));
         end
         done_cnt += len;
      end
   endtask

   // response side: random ready pattern plus one long hold-off
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && sent_count >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         rsp_tready <= 1'b1;
         repeat (pick_run()) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset registers, every button combination but wake with hour, expiry and wake
      send_presses(1, 1'b0, 1'b0, 1'b0);
      send_presses(1, 1'b1, 1'b0, 1'b0);
      send_presses(1, 1'b1, 1'b1, 1'b0);
      send_presses(1, 1'b0, 1'b1, 1'b0);
      send_presses(1, 1'b0, 1'b0, 1'b1);
      send_presses(1, 1'b1, 1'b1, 1'b1);
      send_presses(1, 1'b0, 1'b1, 1'b1);
      send_beat(bcdt_pkg::OP_TICK, 1'b1, 1'b1, 1'b1);
      send_ticks(9);
      send_presses(1, 1'b0, 1'b0, 1'b0);
      send_ticks(1);
      send_presses(1, 1'b0, 1'b1, 1'b0);
      send_presses(1, 1'b1, 1'b1, 1'b0);
      wait_drained();

      // long timeout, walk minutes and hours through their carries and wraps
      load_regs(8'hFF, rand_table(), rand_table(), 1'b0);
      send_presses(57, 1'b0, 1'b1, 1'b0);
      send_ticks(60);
      send_presses(7, 1'b0, 1'b0, 1'b1);
      send_presses(59, 1'b0, 1'b1, 1'b0);
      send_ticks(60);
      send_presses(24, 1'b0, 1'b0, 1'b1);
      wait_drained();

      load_regs(8'd1, '0, '1, 1'b0);
      run_random(45);
      wait_drained();

      // zero reload: once the timeout runs out, the display stays blank
      load_regs(8'd0, rand_table(), rand_table(), 1'b1);
      run_random(45);
      wait_drained();

      load_regs(8'hFF, '1, '0, 1'b0);
      run_random(45);
      wait_drained();

      load_regs(bcdt_pkg::TMO_W'($urandom_range(2, 30)), rand_table(), rand_table(), 1'b0);
      run_random(45);
      wait_drained();

      load_regs(bcdt_pkg::RELOAD_RESET, bcdt_pkg::MINUTE_TBL_RESET,
                bcdt_pkg::HOUR_TBL_RESET, 1'b1);
      run_random(45);
      wait_drained();

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
